// ===== rtl/udp_frame_4b5b_nrzi_transmitter_defines.svh =====
// Assertion macros used by the checker file of the UDP line transmitter.
`ifndef UDP_FRAME_4B5B_NRZI_TRANSMITTER_DEFINES_SVH
`define UDP_FRAME_4B5B_NRZI_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UDPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UDPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/udpt_pkg.sv =====
// Package: types, constants and coding functions of the UDP line transmitter.
`timescale 1ns / 1ps
package udpt_pkg;

    localparam int LEN_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int IDX_W       = 6;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 11'd1472;
    localparam logic [LEN_W-1:0] MIN_PAYLOAD = 11'd2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_IP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PORT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_PORT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 3'd6;

    // control symbols
    localparam logic [4:0] SYM_J = 5'b11000;
    localparam logic [4:0] SYM_K = 5'b10001;
    localparam logic [4:0] SYM_T = 5'b01101;
    localparam logic [4:0] SYM_R = 5'b00111;
    localparam logic [4:0] SYM_I = 5'b11111;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [7:0]  PREAMBLE   = 8'h55;
    localparam logic [7:0]  SFD        = 8'hD5;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL = 8'h45;
    localparam logic [7:0]  IP_TTL     = 8'h80;
    localparam logic [7:0]  IP_PROTO   = 8'h11;
    // version/IHL word plus TTL/protocol word, the fixed part of the header sum
    localparam logic [15:0] CSUM_SEED  = 16'hC511;
    localparam logic [15:0] IP_OVERHEAD  = 16'd28;
    localparam logic [15:0] UDP_OVERHEAD = 16'd8;

    // header word positions: JK, seven preamble bytes, SFD, 42 header bytes
    localparam logic [IDX_W-1:0] SFD_IDX      = 6'd8;
    localparam logic [IDX_W-1:0] HDR_LAST_IDX = 6'd50;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_HEAD,
        ST_DATA,
        ST_FCS,
        ST_TERM,
        ST_IDLE
    } t_back_state;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       data;
        logic             first;
        logic             last;
        logic [LEN_W-1:0] len;
    } t_fifo_entry;

    function automatic logic [4:0] enc45(input logic [3:0] nib);
        logic [4:0] s;
        unique case (nib)
            4'h0: s = 5'h1E;
            4'h1: s = 5'h09;
            4'h2: s = 5'h14;
            4'h3: s = 5'h15;
            4'h4: s = 5'h0A;
            4'h5: s = 5'h0B;
            4'h6: s = 5'h0E;
            4'h7: s = 5'h0F;
            4'h8: s = 5'h12;
            4'h9: s = 5'h13;
            4'hA: s = 5'h16;
            4'hB: s = 5'h17;
            4'hC: s = 5'h1A;
            4'hD: s = 5'h1B;
            4'hE: s = 5'h1C;
            default: s = 5'h1D;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // two symbols, MSB of each sent first; returns {new level, line bits}
    function automatic logic [10:0] nrzi_pair(input logic lvl_in, input logic [4:0] s0,
                                              input logic [4:0] s1);
        logic [9:0] bits;
        logic [9:0] w;
        logic       lvl;
        bits = {s1[0], s1[1], s1[2], s1[3], s1[4], s0[0], s0[1], s0[2], s0[3], s0[4]};
        lvl  = lvl_in;
        for (int i = 0; i < 10; i++) begin
            lvl  = lvl ^ bits[i];
            w[i] = lvl;
        end
        return {lvl, w};
    endfunction

endpackage

// ===== rtl/udpt_stream_if.sv =====
// Stream interfaces: payload bytes in, line words out.
`timescale 1ns / 1ps
interface udpt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;

    modport source (output valid, output payload_byte, input ready);
    modport sink (input valid, input payload_byte, output ready);
endinterface

interface udpt_word_if;
    logic       valid;
    logic       ready;
    logic [9:0] line_word;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output line_word, output run_last, output frame_end,
                    input ready);
    modport sink (input valid, input line_word, input run_last, input frame_end,
                  output ready);
endinterface

// ===== rtl/udpt_fifo.sv =====
// Short queue of classified payload words between front and back.
`timescale 1ns / 1ps
module udpt_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  udpt_pkg::t_fifo_entry i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output udpt_pkg::t_fifo_entry o_entry
);

    udpt_pkg::t_fifo_entry r_mem [udpt_pkg::FIFO_DEPTH];
    logic [udpt_pkg::FIFO_AW-1:0] r_wr;
    logic [udpt_pkg::FIFO_AW-1:0] r_rd;
    logic [udpt_pkg::FIFO_AW:0]   r_cnt;
    logic [udpt_pkg::FIFO_AW:0]   n_cnt;

    assign o_full  = (r_cnt == (udpt_pkg::FIFO_AW + 1)'(udpt_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== rtl/udpt_front.sv =====
// Front: accepts payload words, counts them and marks frame start and end.
`timescale 1ns / 1ps
module udpt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    udpt_byte_if.sink                      i_byte,
    input  logic [udpt_pkg::LEN_W-1:0]     i_payload_length,
    input  logic                           i_full,
    output logic                           o_push,
    output udpt_pkg::t_fifo_entry          o_entry
);

    logic [udpt_pkg::LEN_W-1:0] r_count;
    logic [udpt_pkg::LEN_W-1:0] w_eff;
    logic [udpt_pkg::LEN_W-1:0] w_cnt1;
    logic                       w_last;

    assign i_byte.ready = ~i_full;
    assign o_push       = i_byte.valid && !i_full;

    always_comb begin
        // clamp the length into the supported range
        if (i_payload_length > udpt_pkg::MAX_PAYLOAD) begin
            w_eff = udpt_pkg::MAX_PAYLOAD;
        end else if (i_payload_length < udpt_pkg::MIN_PAYLOAD) begin
            w_eff = udpt_pkg::MIN_PAYLOAD;
        end else begin
            w_eff = i_payload_length;
        end
        w_cnt1        = r_count + 1'b1;
        w_last        = (w_cnt1 >= w_eff);
        o_entry.data  = i_byte.payload_byte;
        o_entry.first = (r_count == '0);
        o_entry.last  = w_last;
        o_entry.len   = w_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= w_last ? '0 : w_cnt1;
        end
    end

endmodule

// ===== rtl/udpt_back.sv =====
// Back: frame sequencer, header build, CRC, 4B5B/NRZI coding and output register.
`timescale 1ns / 1ps
module udpt_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  udpt_pkg::t_cfg        i_cfg,
    input  logic                  i_q_valid,
    input  udpt_pkg::t_fifo_entry i_q_entry,
    output logic                  o_q_pop,
    udpt_word_if.source           o_word
);

    udpt_pkg::t_back_state         r_state;
    udpt_pkg::t_back_state         n_state;
    logic [udpt_pkg::IDX_W-1:0]    r_idx;
    logic [udpt_pkg::IDX_W-1:0]    n_idx;
    logic [15:0]                   r_ident;
    logic [udpt_pkg::LEN_W-1:0]    r_len;
    logic [18:0]                   r_csum;
    logic [18:0]                   n_csum;
    logic [31:0]                   r_fcs;
    logic                          r_level;
    logic [9:0]                    r_oword;
    logic                          r_olast;
    logic                          r_oend;
    logic                          r_ovalid;

    logic        w_free;
    logic        w_go;
    logic        w_use_byte;
    logic [7:0]  w_byte;
    logic [7:0]  w_hdr_byte;
    logic [4:0]  w_csym0;
    logic [4:0]  w_csym1;
    logic [4:0]  w_sym0;
    logic [4:0]  w_sym1;
    logic        w_crc_en;
    logic        w_crc_init;
    logic        w_last;
    logic        w_end;
    logic        w_start;
    logic [10:0] w_coded;
    logic [15:0] w_total;
    logic [15:0] w_udp_len;
    logic [15:0] w_ck;
    logic [31:0] w_fcs_out;
    logic [15:0] w_term;

    assign o_word.valid     = r_ovalid;
    assign o_word.line_word = r_oword;
    assign o_word.run_last  = r_olast;
    assign o_word.frame_end = r_oend;

    assign w_free    = !r_ovalid || o_word.ready;
    assign w_total   = {5'd0, r_len} + udpt_pkg::IP_OVERHEAD;
    assign w_udp_len = {5'd0, r_len} + udpt_pkg::UDP_OVERHEAD;
    assign w_ck      = ~r_csum[15:0];
    assign w_fcs_out = ~r_fcs;
    assign w_start   = (r_state == udpt_pkg::ST_WAIT) && i_q_entry.first;

    always_comb begin
        unique case (r_state)
            udpt_pkg::ST_WAIT, udpt_pkg::ST_DATA: w_go = w_free && i_q_valid;
            default:                              w_go = w_free;
        endcase
    end

    // header and preamble bytes by word position
    always_comb begin
        case (r_idx) inside
            [6'd1:6'd7]: w_hdr_byte = udpt_pkg::PREAMBLE;
            6'd8:  w_hdr_byte = udpt_pkg::SFD;
            6'd9:  w_hdr_byte = i_cfg.dest_mac[47:40];
            6'd10: w_hdr_byte = i_cfg.dest_mac[39:32];
            6'd11: w_hdr_byte = i_cfg.dest_mac[31:24];
            6'd12: w_hdr_byte = i_cfg.dest_mac[23:16];
            6'd13: w_hdr_byte = i_cfg.dest_mac[15:8];
            6'd14: w_hdr_byte = i_cfg.dest_mac[7:0];
            6'd15: w_hdr_byte = i_cfg.source_mac[47:40];
            6'd16: w_hdr_byte = i_cfg.source_mac[39:32];
            6'd17: w_hdr_byte = i_cfg.source_mac[31:24];
            6'd18: w_hdr_byte = i_cfg.source_mac[23:16];
            6'd19: w_hdr_byte = i_cfg.source_mac[15:8];
            6'd20: w_hdr_byte = i_cfg.source_mac[7:0];
            6'd21: w_hdr_byte = udpt_pkg::ETHERTYPE_IPV4[15:8];
            6'd22: w_hdr_byte = udpt_pkg::ETHERTYPE_IPV4[7:0];
            6'd23: w_hdr_byte = udpt_pkg::IP_VER_IHL;
            6'd25: w_hdr_byte = w_total[15:8];
            6'd26: w_hdr_byte = w_total[7:0];
            6'd27: w_hdr_byte = r_ident[15:8];
            6'd28: w_hdr_byte = r_ident[7:0];
            6'd31: w_hdr_byte = udpt_pkg::IP_TTL;
            6'd32: w_hdr_byte = udpt_pkg::IP_PROTO;
            6'd33: w_hdr_byte = w_ck[15:8];
            6'd34: w_hdr_byte = w_ck[7:0];
            6'd35: w_hdr_byte = i_cfg.source_ip[31:24];
            6'd36: w_hdr_byte = i_cfg.source_ip[23:16];
            6'd37: w_hdr_byte = i_cfg.source_ip[15:8];
            6'd38: w_hdr_byte = i_cfg.source_ip[7:0];
            6'd39: w_hdr_byte = i_cfg.dest_ip[31:24];
            6'd40: w_hdr_byte = i_cfg.dest_ip[23:16];
            6'd41: w_hdr_byte = i_cfg.dest_ip[15:8];
            6'd42: w_hdr_byte = i_cfg.dest_ip[7:0];
            6'd43: w_hdr_byte = i_cfg.source_port[15:8];
            6'd44: w_hdr_byte = i_cfg.source_port[7:0];
            6'd45: w_hdr_byte = i_cfg.dest_port[15:8];
            6'd46: w_hdr_byte = i_cfg.dest_port[7:0];
            6'd47: w_hdr_byte = w_udp_len[15:8];
            6'd48: w_hdr_byte = w_udp_len[7:0];
            default: w_hdr_byte = 8'h00;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (w_go) begin
            unique case (r_state)
                udpt_pkg::ST_WAIT: begin
                    if (i_q_entry.first) begin
                        n_state = udpt_pkg::ST_HEAD;
                        n_idx   = 6'd1;
                    end else if (i_q_entry.last) begin
                        n_state = udpt_pkg::ST_FCS;
                        n_idx   = '0;
                    end
                end
                udpt_pkg::ST_HEAD: begin
                    if (r_idx == udpt_pkg::HDR_LAST_IDX) begin
                        n_state = udpt_pkg::ST_DATA;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                udpt_pkg::ST_DATA: begin
                    n_state = i_q_entry.last ? udpt_pkg::ST_FCS : udpt_pkg::ST_WAIT;
                    n_idx   = '0;
                end
                udpt_pkg::ST_FCS: begin
                    if (r_idx[1:0] == 2'd3) begin
                        n_state = udpt_pkg::ST_TERM;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                udpt_pkg::ST_TERM: n_state = udpt_pkg::ST_IDLE;
                udpt_pkg::ST_IDLE: n_state = udpt_pkg::ST_WAIT;
                default:           n_state = udpt_pkg::ST_WAIT;
            endcase
        end
    end

    // outputs of the sequencer
    always_comb begin
        w_use_byte = 1'b0;
        w_byte     = 8'h00;
        w_csym0    = 5'd0;
        w_csym1    = 5'd0;
        w_crc_en   = 1'b0;
        w_crc_init = 1'b0;
        w_last     = 1'b0;
        w_end      = 1'b0;
        o_q_pop    = 1'b0;
        unique case (r_state)
            udpt_pkg::ST_WAIT, udpt_pkg::ST_DATA: begin
                if (w_start) begin
                    w_csym0 = udpt_pkg::SYM_J;
                    w_csym1 = udpt_pkg::SYM_K;
                end else begin
                    w_use_byte = 1'b1;
                    w_byte     = i_q_entry.data;
                    w_crc_en   = 1'b1;
                    w_last     = !i_q_entry.last;
                    o_q_pop    = w_go;
                end
            end
            udpt_pkg::ST_HEAD: begin
                w_use_byte = 1'b1;
                w_byte     = w_hdr_byte;
                w_crc_en   = (r_idx > udpt_pkg::SFD_IDX);
                w_crc_init = (r_idx == udpt_pkg::SFD_IDX);
            end
            udpt_pkg::ST_FCS: begin
                w_use_byte = 1'b1;
                case (r_idx[1:0])
                    2'd0:    w_byte = w_fcs_out[7:0];
                    2'd1:    w_byte = w_fcs_out[15:8];
                    2'd2:    w_byte = w_fcs_out[23:16];
                    default: w_byte = w_fcs_out[31:24];
                endcase
            end
            udpt_pkg::ST_TERM: begin
                w_csym0 = udpt_pkg::SYM_T;
                w_csym1 = udpt_pkg::SYM_R;
            end
            udpt_pkg::ST_IDLE: begin
                w_csym0    = udpt_pkg::SYM_I;
                w_csym1    = udpt_pkg::SYM_I;
                w_last     = 1'b1;
                w_end      = 1'b1;
                w_crc_init = 1'b1;
            end
            default: begin
                w_csym0 = 5'd0;
            end
        endcase
    end

    assign w_sym0  = w_use_byte ? udpt_pkg::enc45(w_byte[3:0]) : w_csym0;
    assign w_sym1  = w_use_byte ? udpt_pkg::enc45(w_byte[7:4]) : w_csym1;
    assign w_coded = udpt_pkg::nrzi_pair(r_level, w_sym0, w_sym1);

    // header checksum: one term per preamble word, then two folds
    always_comb begin
        w_term = 16'd0;
        case (r_idx)
            6'd2:    w_term = w_total;
            6'd3:    w_term = r_ident;
            6'd4:    w_term = i_cfg.source_ip[31:16];
            6'd5:    w_term = i_cfg.source_ip[15:0];
            6'd6:    w_term = i_cfg.dest_ip[31:16];
            6'd7:    w_term = i_cfg.dest_ip[15:0];
            default: w_term = 16'd0;
        endcase
        case (r_idx) inside
            6'd1:        n_csum = {3'd0, udpt_pkg::CSUM_SEED};
            [6'd2:6'd7]: n_csum = r_csum + {3'd0, w_term};
            6'd8, 6'd9:  n_csum = {3'd0, r_csum[15:0]} + {16'd0, r_csum[18:16]};
            default:     n_csum = r_csum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= udpt_pkg::ST_WAIT;
            r_idx    <= '0;
            r_ident  <= '0;
            r_fcs    <= udpt_pkg::CRC_INIT;
            r_level  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_go) begin
                r_level  <= w_coded[10];
                r_ovalid <= 1'b1;
                if (w_crc_init) begin
                    r_fcs <= udpt_pkg::CRC_INIT;
                end else if (w_crc_en) begin
                    r_fcs <= udpt_pkg::crc_byte(r_fcs, w_byte);
                end
                if (w_start) begin
                    r_ident <= r_ident + 1'b1;
                end
            end else if (o_word.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_oword <= w_coded[9:0];
            r_olast <= w_last;
            r_oend  <= w_end;
            if (w_start) begin
                r_len <= i_q_entry.len;
            end
            if (r_state == udpt_pkg::ST_HEAD) begin
                r_csum <= n_csum;
            end
        end
    end

endmodule

// ===== rtl/udp_frame_4b5b_nrzi_transmitter.sv =====
// Top level of the UDP frame transmitter for a 4B5B/NRZI coded line.
`timescale 1ns / 1ps
// Usage:
//   i_byte  : payload words (one UDP payload byte each), valid/ready handshake.
//             Frames follow one another with no gap; the frame length is taken
//             from the payload_length register (clamped to 2..1472).
//   o_word  : line words, ten NRZI line bits (first bit in bit 0) per word,
//             with run_last on the last word caused by an input word and
//             frame_end on the closing idle word of each frame.
//   i_cfg_* : register writes (MACs, IPs, ports, length); write only while
//             the block is idle.
//   An input word passes through the queue and the output register before
//   its first line word leaves. Throughput: one line word per cycle while
//   the receiver is ready and the queue is not empty where payload is due,
//   set by the single coder in the back end. L payload words give L + 57
//   line words: 51 for the JK, preamble, SFD and headers, L payload words,
//   six for FCS, TR and idle. The front takes one word per cycle until its
//   four-entry queue fills during a header or trailer, then drops ready.
//   Reset: queue empty, IP identifier, line level and byte count cleared,
//   CRC preset to all ones, registers back to their defaults (length 1).
//   Receiver stall: the output register holds its word; the back end stops,
//   the queue fills and ready falls at the input.
module udp_frame_4b5b_nrzi_transmitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    udpt_byte_if.sink                           i_byte,
    udpt_word_if.source                         o_word,
    input  logic                                i_cfg_we,
    input  logic [udpt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [udpt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration registers
    udpt_pkg::t_cfg             r_cfg;
    logic [udpt_pkg::LEN_W-1:0] r_payload_length;

    // front to queue, queue to back
    logic                  w_push;
    logic                  w_full;
    logic                  w_pop;
    logic                  w_q_valid;
    udpt_pkg::t_fifo_entry w_in_entry;
    udpt_pkg::t_fifo_entry w_q_entry;

    // Decode register writes; indexes past the list are dropped, values
    // truncated to the register width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg            <= '0;
            r_payload_length <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                udpt_pkg::CFG_DEST_MAC:    r_cfg.dest_mac    <= i_cfg_data;
                udpt_pkg::CFG_SOURCE_MAC:  r_cfg.source_mac  <= i_cfg_data;
                udpt_pkg::CFG_SOURCE_IP:   r_cfg.source_ip   <= i_cfg_data[31:0];
                udpt_pkg::CFG_DEST_IP:     r_cfg.dest_ip     <= i_cfg_data[31:0];
                udpt_pkg::CFG_SOURCE_PORT: r_cfg.source_port <= i_cfg_data[15:0];
                udpt_pkg::CFG_DEST_PORT:   r_cfg.dest_port   <= i_cfg_data[15:0];
                udpt_pkg::CFG_PAYLOAD_LEN:
                    r_payload_length <= i_cfg_data[udpt_pkg::LEN_W-1:0];
                default: r_payload_length <= r_payload_length;
            endcase
        end
    end

    // Front: take words, count them, tag frame start/end and the length.
    udpt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte           (i_byte),
        .i_payload_length (r_payload_length),
        .i_full           (w_full),
        .o_push           (w_push),
        .o_entry          (w_in_entry)
    );

    // Queue: lets the front run on while the back sends headers or trailers.
    udpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    // Back: expand tagged words into line words, one per cycle if not stalled.
    udpt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_q_entry),
        .o_q_pop   (w_pop),
        .o_word    (o_word)
    );

endmodule

// ===== rtl/udpt_checker.sv =====
// Port-level checker for the UDP line transmitter, bound to the top level.
`timescale 1ns / 1ps
`include "udp_frame_4b5b_nrzi_transmitter_defines.svh"
module udpt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [9:0] i_line_word,
    input logic       i_run_last,
    input logic       i_frame_end
);

    // hold a stalled word
    `UDPT_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_line_word), "stalled line word changed")

    // the closing idle word always ends the run of its input word
    `UDPT_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, i_out_valid && i_frame_end, i_run_last, "frame end without run end")

    // two idle symbols toggle the line on every bit
    `UDPT_ASSERT_IMP(a_idle_pattern, i_clk, i_rst_n, i_out_valid && i_frame_end, (i_line_word == 10'h155) || (i_line_word == 10'h2AA), "frame end word is not idle")

endmodule

bind udp_frame_4b5b_nrzi_transmitter udpt_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_word.valid),
    .i_out_ready (o_word.ready),
    .i_line_word (o_word.line_word),
    .i_run_last  (o_word.run_last),
    .i_frame_end (o_word.frame_end)
);

// ===== tb/sv/tb_udp_frame_4b5b_nrzi_transmitter.sv =====
// Testbench: self-checking run of the UDP line transmitter against a line-word scoreboard.
`timescale 1ns / 1ps
module tb_udp_frame_4b5b_nrzi_transmitter;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int DRAIN_CYCLES   = 8;       // queue plus output register, with margin
    localparam int IDLE_PCT       = 23;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int LONGEST_FRAME  = 1472;
    localparam int RANDOM_PHASES  = 6;

    // index past the end of the register list; the block must ignore it
    localparam logic [udpt_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    // line coding constants
    localparam logic [4:0]  LINE_J      = 5'b11000;
    localparam logic [4:0]  LINE_K      = 5'b10001;
    localparam logic [4:0]  LINE_T      = 5'b01101;
    localparam logic [4:0]  LINE_R      = 5'b00111;
    localparam logic [4:0]  LINE_IDLE   = 5'b11111;
    localparam logic [15:0][4:0] NIBBLE_CODES = {
        5'h1D, 5'h1C, 5'h1B, 5'h1A, 5'h17, 5'h16, 5'h13, 5'h12,
        5'h0F, 5'h0E, 5'h0B, 5'h0A, 5'h15, 5'h14, 5'h09, 5'h1E
    };
    localparam logic [31:0] FCS_POLY    = 32'hEDB88320;
    localparam logic [31:0] FCS_START   = 32'hFFFFFFFF;
    localparam logic [7:0]  PREAMBLE_OCTET = 8'h55;
    localparam logic [7:0]  SFD_OCTET   = 8'hD5;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  VERSION_IHL = 8'h45;
    localparam logic [7:0]  HOP_LIMIT   = 8'h80;
    localparam logic [7:0]  PROTO_UDP   = 8'h11;

    typedef struct packed {
        logic [9:0] line_word;
        logic       run_last;
        logic       frame_end;
    } t_line_result;

    // Register copies, frame state and the line words still owed by the block.
    class line_scoreboard;
        logic [47:0]  dest_mac;
        logic [47:0]  source_mac;
        logic [31:0]  source_ip;
        logic [31:0]  dest_ip;
        logic [15:0]  source_port;
        logic [15:0]  dest_port;
        logic [10:0]  length_reg;
        logic [15:0]  ip_ident;
        logic [31:0]  fcs_acc;
        logic         line_level;
        logic [10:0]  payload_count;
        t_line_result owed_words[$];
        int unsigned  mismatches;

        function new();
            dest_mac      = '0;
            source_mac    = '0;
            source_ip     = '0;
            dest_ip       = '0;
            source_port   = '0;
            dest_port     = '0;
            length_reg    = 11'd1;
            ip_ident      = '0;
            fcs_acc       = FCS_START;
            line_level    = 1'b0;
            payload_count = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [udpt_pkg::CFG_IDX_W-1:0] idx,
                              logic [udpt_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                udpt_pkg::CFG_DEST_MAC:    dest_mac    = data[47:0];
                udpt_pkg::CFG_SOURCE_MAC:  source_mac  = data[47:0];
                udpt_pkg::CFG_SOURCE_IP:   source_ip   = data[31:0];
                udpt_pkg::CFG_DEST_IP:     dest_ip     = data[31:0];
                udpt_pkg::CFG_SOURCE_PORT: source_port = data[15:0];
                udpt_pkg::CFG_DEST_PORT:   dest_port   = data[15:0];
                udpt_pkg::CFG_PAYLOAD_LEN: length_reg  = data[10:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        // NRZI: toggle the line on a one, first symbol bit is its MSB
        function logic [4:0] nrzi_symbol(logic [4:0] sym);
            logic [4:0] bits;
            for (int b = 4; b >= 0; b--) begin
                if (sym[b])
                    line_level = ~line_level;
                bits[4-b] = line_level;
            end
            return bits;
        endfunction

        function void push_pair(logic [4:0] s0, logic [4:0] s1, logic fe);
            t_line_result r;
            r.line_word[4:0] = nrzi_symbol(s0);
            r.line_word[9:5] = nrzi_symbol(s1);
            r.run_last       = 1'b0;
            r.frame_end      = fe;
            owed_words.push_back(r);
        endfunction

        function void push_octet(logic [7:0] v, bit in_fcs);
            logic [31:0] c;
            if (in_fcs) begin
                c = fcs_acc ^ {24'd0, v};
                for (int k = 0; k < 8; k++)
                    c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
                fcs_acc = c;
            end
            push_pair(NIBBLE_CODES[v[3:0]], NIBBLE_CODES[v[7:4]], 1'b0);
        endfunction

        function logic [10:0] frame_length();
            if (length_reg > LONGEST_FRAME)
                return 11'(LONGEST_FRAME);
            if (length_reg < 11'd2)
                return 11'd2;
            return length_reg;
        endfunction

        function void push_headers(logic [10:0] len);
            logic [7:0]  hdr [42];
            logic [15:0] total;
            logic [15:0] udp_len;
            logic [31:0] sum;
            logic [15:0] csum;
            ip_ident = ip_ident + 16'd1;
            total    = {5'd0, len} + 16'd28;
            udp_len  = {5'd0, len} + 16'd8;
            sum = {VERSION_IHL, 8'h00} + total + ip_ident + {HOP_LIMIT, PROTO_UDP}
                + source_ip[31:16] + source_ip[15:0] + dest_ip[31:16] + dest_ip[15:0];
            sum  = {16'd0, sum[15:0]} + (sum >> 16);
            sum  = {16'd0, sum[15:0]} + (sum >> 16);
            csum = ~sum[15:0];
            for (int i = 0; i < 6; i++) begin
                hdr[i]     = dest_mac[47-8*i -: 8];
                hdr[6 + i] = source_mac[47-8*i -: 8];
            end
            hdr[12] = ETHERTYPE_IPV4[15:8];
            hdr[13] = ETHERTYPE_IPV4[7:0];
            hdr[14] = VERSION_IHL;
            hdr[15] = 8'h00;
            hdr[16] = total[15:8];
            hdr[17] = total[7:0];
            hdr[18] = ip_ident[15:8];
            hdr[19] = ip_ident[7:0];
            hdr[20] = 8'h00;
            hdr[21] = 8'h00;
            hdr[22] = HOP_LIMIT;
            hdr[23] = PROTO_UDP;
            hdr[24] = csum[15:8];
            hdr[25] = csum[7:0];
            for (int i = 0; i < 4; i++) begin
                hdr[26 + i] = source_ip[31-8*i -: 8];
                hdr[30 + i] = dest_ip[31-8*i -: 8];
            end
            hdr[34] = source_port[15:8];
            hdr[35] = source_port[7:0];
            hdr[36] = dest_port[15:8];
            hdr[37] = dest_port[7:0];
            hdr[38] = udp_len[15:8];
            hdr[39] = udp_len[7:0];
            hdr[40] = 8'h00;
            hdr[41] = 8'h00;
            push_pair(LINE_J, LINE_K, 1'b0);
            for (int i = 0; i < 7; i++)
                push_octet(PREAMBLE_OCTET, 1'b0);
            push_octet(SFD_OCTET, 1'b0);
            fcs_acc = FCS_START;
            for (int i = 0; i < 42; i++)
                push_octet(hdr[i], 1'b1);
        endfunction

        // Work out the line words that one accepted payload byte causes.
        function void note_byte(logic [7:0] v);
            logic [10:0] len;
            logic [31:0] fcs;
            len = frame_length();
            if (payload_count == 0)
                push_headers(len);
            push_octet(v, 1'b1);
            payload_count = payload_count + 11'd1;
            if (payload_count >= len) begin
                fcs = ~fcs_acc;
                push_octet(fcs[7:0], 1'b0);
                push_octet(fcs[15:8], 1'b0);
                push_octet(fcs[23:16], 1'b0);
                push_octet(fcs[31:24], 1'b0);
                push_pair(LINE_T, LINE_R, 1'b0);
                push_pair(LINE_IDLE, LINE_IDLE, 1'b1);
                fcs_acc       = FCS_START;
                payload_count = '0;
            end
            owed_words[owed_words.size()-1].run_last = 1'b1;
        endfunction

        function void check_word(t_line_result got);
            t_line_result want;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word %h last %b end %b at %0t",
                             got.line_word, got.run_last, got.frame_end, $realtime);
                return;
            end
            want = owed_words.pop_front();
            if (got.line_word !== want.line_word || got.run_last !== want.run_last
                    || got.frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("word mismatch at %0t: expected %h/%b/%b, got %h/%b/%b",
                             $realtime, want.line_word, want.run_last, want.frame_end,
                             got.line_word, got.run_last, got.frame_end);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [udpt_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [udpt_pkg::CFG_DATA_W-1:0] cfg_data;

    // steady: neither side idles; squeeze_armed: ask the receiver for one long hold-off
    bit          steady        = 1'b0;
    bit          squeeze_armed = 1'b0;
    bit          squeeze_done  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    line_scoreboard board;

    udpt_byte_if byte_ch ();
    udpt_word_if word_ch ();

    udp_frame_4b5b_nrzi_transmitter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_word     (word_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Watchdog: give up if the run overstays its limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: stall at random, hold off once for a long stretch on request,
    // and never stall during the steady phase.
    always @(posedge i_clk) begin
        if (squeeze_armed && !squeeze_done) begin
            squeeze_done  <= 1'b1;
            hold_left     <= SQUEEZE_CYCLES;
            word_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            word_ch.ready <= 1'b0;
        end else begin
            word_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: check every line word taken from the block.
    always @(posedge i_clk) begin
        if (i_rst_n && word_ch.valid && word_ch.ready)
            board.check_word({word_ch.line_word, word_ch.run_last, word_ch.frame_end});
    end

    // Offer one payload word; valid stays high into the next call unless it idles.
    task automatic offer_byte(input logic [7:0] v);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.payload_byte <= v;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        board.note_byte(v);
    endtask

    // One register write: raise the enable for a single edge, then drop it.
    task automatic write_reg(input logic [udpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [udpt_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        board.set_reg(idx, data);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Drop valid, wait for every owed word, then let the pipeline run dry.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [47:0] random48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    // Fresh addresses and ports with junk above each narrower register's width, and a
    // mostly short frame length so that many frames close within a phase.
    task automatic randomise_regs();
        logic [10:0] len;
        logic [47:0] len_data;
        case ($urandom_range(0, 9))
            0:       len = 11'd0;
            1:       len = 11'd1;
            2:       len = 11'($urandom_range(9, 40));
            default: len = 11'($urandom_range(2, 6));
        endcase
        len_data       = random48();
        len_data[10:0] = len;
        write_reg(udpt_pkg::CFG_DEST_MAC, random48());
        write_reg(udpt_pkg::CFG_SOURCE_MAC, random48());
        write_reg(udpt_pkg::CFG_SOURCE_IP, random48());
        write_reg(udpt_pkg::CFG_DEST_IP, random48());
        write_reg(udpt_pkg::CFG_SOURCE_PORT, random48());
        write_reg(udpt_pkg::CFG_DEST_PORT, random48());
        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, len_data);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_NONE, random48());
    endtask

    initial begin
        board = new();
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        byte_ch.valid        = 1'b0;
        byte_ch.payload_byte = '0;
        word_ch.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: zero addresses, length 1 taken as 2.
        offer_byte(8'h00);
        offer_byte(8'hFF);
        settle();

        // All-ones addresses and ports push carries through the header checksum;
        // the length write carries junk above bit 10 and leaves zero, taken as 2.
        write_reg(udpt_pkg::CFG_DEST_MAC, '1);
        write_reg(udpt_pkg::CFG_SOURCE_MAC, '1);
        write_reg(udpt_pkg::CFG_SOURCE_IP, '1);
        write_reg(udpt_pkg::CFG_DEST_IP, '1);
        write_reg(udpt_pkg::CFG_SOURCE_PORT, '1);
        write_reg(udpt_pkg::CFG_DEST_PORT, '1);
        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, 48'hFFFF_FFFF_F800);
        write_reg(CFG_NONE, '1);
        offer_byte(8'hFF);
        offer_byte(8'h0F);
        settle();

        // Longest length: open a frame, raise the length past the limit mid-frame,
        // then drop it below the count so that the next byte closes the frame.
        write_reg(udpt_pkg::CFG_DEST_MAC, '0);
        write_reg(udpt_pkg::CFG_SOURCE_IP, '0);
        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, 48'(LONGEST_FRAME));
        offer_byte(8'hF0);
        offer_byte(8'hA5);
        settle();
        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, 48'h7FF);
        offer_byte(8'h5A);
        settle();
        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, 48'd2);
        offer_byte(8'h3C);
        settle();

        // Header of a clamped length, then close on the count meeting the minimum.
        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, 48'h7FF);
        offer_byte(8'hC3);
        settle();
        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, 48'd1);
        offer_byte(8'h81);
        settle();

        write_reg(udpt_pkg::CFG_PAYLOAD_LEN, 48'd3);
        offer_byte(8'h7E);
        offer_byte(8'h01);
        offer_byte(8'h80);
        settle();
        // The identifier wrap needs 65536 frames and lies beyond this run.

        // Random phases: new registers each time; one phase with no idling
        // at all, one with a long receiver hold-off that backs up the input.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            randomise_regs();
            steady <= (p == 2);
            if (p == 4)
                squeeze_armed <= 1'b1;
            repeat ((p == 2) ? 40 : $urandom_range(15, 22))
                offer_byte(8'($urandom_range(0, 255)));
            settle();
        end

        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
